/* hdl/lru_pkg.sv */
package lru_pkg;

  // fixed field widths of the channels
  localparam int PAGE_W  = 16;
  localparam int FIDX_W  = 4;
  localparam int CFG_W   = 5;
  localparam int COUNT_W = 32;

  // frames_in_use after reset
  localparam logic [CFG_W-1:0] FIU_RESET = 5'd16;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
  } lru_req_t;

  typedef struct packed {
    logic               hit;
    logic [FIDX_W-1:0]  frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
  } lru_rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] frames_in_use;
  } lru_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } lru_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic look;
    logic commit;
  } lru_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } lru_stat_t;

endpackage

/* hdl/lru_if.sv */
interface lru_req_if import lru_pkg::*;;
  logic     valid;
  logic     ready;
  lru_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lru_rsp_if import lru_pkg::*;;
  logic     valid;
  logic     ready;
  lru_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lru_cfg_if import lru_pkg::*;;
  logic     valid;
  logic     ready;
  lru_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/lru_ctrl.sv */
module lru_ctrl import lru_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  lru_stat_t stat,
  output lru_cmd_t  cmd
);

  lru_state_t state;
  lru_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (stat.out_free) begin
          state_next = req_valid ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: a new request is taken in the cycle the previous one commits
  always_comb begin
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
      end
      ST_UPD: begin
        cmd.commit = stat.out_free;
        req_ready  = stat.out_free;
        cmd.load   = stat.out_free && req_valid;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // a commit always follows a lookup
  a_commit_after_look: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> ($past(state) == ST_LOOK || $past(state) == ST_UPD))
    else $error("commit without a preceding lookup");

  // lookup only for a request that was loaded the cycle before
  a_look_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.look |-> $past(cmd.load))
    else $error("lookup without a loaded request");

endmodule

/* hdl/lru_dp.sv */
module lru_dp import lru_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  lru_cmd_t          cmd,
  output lru_stat_t         stat,
  input  logic [PAGE_W-1:0] req_page,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_value,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lru_rsp_t          rsp_data
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(FRAMES + 32);
  localparam int LEAVES = 1 << IDX_W;

  // frame store, ranks (0 = most recent) among valid frames
  logic [FRAMES-1:0]    frame_valid;
  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [RANK_W-1:0]    rank [FRAMES];
  logic [COUNT_W-1:0]   faults;
  logic [CFG_W-1:0]     fiu;

  // request and lookup results
  logic [PAGE_BITS-1:0] cur_page;
  logic [FRAMES-1:0]    match_vec;
  logic [FRAMES-1:0]    empty_vec;
  logic [IDX_W-1:0]     lru_idx;

  // active frame count and mask
  logic [CNT_W-1:0]  n_nz;
  logic [CNT_W-1:0]  n_eff;
  logic [FRAMES-1:0] active;

  always_comb begin
    n_nz  = (fiu == '0) ? CNT_W'(1) : CNT_W'(fiu);
    n_eff = (n_nz > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : n_nz;
    for (int f = 0; f < FRAMES; f++) begin
      active[f] = CNT_W'(f) < n_eff;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fiu <= FIU_RESET;
    end else if (cfg_we) begin
      fiu <= cfg_value;
    end
  end

  // page masked to the stored width
  logic [PAGE_W+PAGE_BITS-1:0] page_wide;
  assign page_wide = {{PAGE_BITS{1'b0}}, req_page};

  always_ff @(posedge clk) begin
    if (cmd.load) cur_page <= page_wide[PAGE_BITS-1:0];
  end

  // least recently used active frame: max-rank tree, ties to the lower frame
  logic              t_act  [2*LEAVES];
  logic [RANK_W-1:0] t_rank [2*LEAVES];
  logic [IDX_W-1:0]  t_idx  [2*LEAVES];

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < FRAMES) begin
        t_act[LEAVES+i]  = active[i];
        t_rank[LEAVES+i] = rank[i];
      end else begin
        t_act[LEAVES+i]  = 1'b0;
        t_rank[LEAVES+i] = '0;
      end
      t_idx[LEAVES+i] = IDX_W'(i);
    end
    t_act[0]  = 1'b0;
    t_rank[0] = '0;
    t_idx[0]  = '0;
    for (int i = LEAVES - 1; i >= 1; i--) begin
      if (t_act[2*i+1] && (!t_act[2*i] || t_rank[2*i+1] > t_rank[2*i])) begin
        t_act[i]  = 1'b1;
        t_rank[i] = t_rank[2*i+1];
        t_idx[i]  = t_idx[2*i+1];
      end else begin
        t_act[i]  = t_act[2*i];
        t_rank[i] = t_rank[2*i];
        t_idx[i]  = t_idx[2*i];
      end
    end
  end

  // lookup stage: tag compare, free frames, lru frame
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      for (int f = 0; f < FRAMES; f++) begin
        match_vec[f] <= active[f] && frame_valid[f] && (frame_page[f] == cur_page);
        empty_vec[f] <= active[f] && !frame_valid[f];
      end
      lru_idx <= t_idx[1];
    end
  end

  function automatic logic [IDX_W-1:0] first_set(input logic [FRAMES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (vec[f]) idx = IDX_W'(f);
    end
    return idx;
  endfunction

  // update stage decisions
  logic              hit;
  logic              any_empty;
  logic              evict;
  logic [IDX_W-1:0]  chosen;
  logic [RANK_W-1:0] old_rank;
  logic [COUNT_W-1:0] faults_new;
  logic [PAGE_W+PAGE_BITS-1:0] ev_wide;
  logic [FIDX_W+IDX_W-1:0]     idx_wide;

  always_comb begin
    hit        = |match_vec;
    any_empty  = |empty_vec;
    evict      = !hit && !any_empty;
    chosen     = hit ? first_set(match_vec) : (any_empty ? first_set(empty_vec) : lru_idx);
    old_rank   = rank[chosen];
    faults_new = (!hit && faults != '1) ? faults + COUNT_W'(1) : faults;
    ev_wide    = {{PAGE_W{1'b0}}, frame_page[chosen]};
    idx_wide   = {{FIDX_W{1'b0}}, chosen};
  end

  // frame store and rank update
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
    end else if (cmd.commit && !hit && any_empty) begin
      frame_valid[chosen] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int g = 0; g < FRAMES; g++) begin
        if (IDX_W'(g) == chosen) begin
          rank[g] <= '0;
        end else if (frame_valid[g] && (!(hit || evict) || rank[g] < old_rank)) begin
          rank[g] <= rank[g] + RANK_W'(1);
        end
      end
      if (!hit) frame_page[chosen] <= cur_page;
    end
  end

  // saturating fault counter
  always_ff @(posedge clk) begin
    if (rst) begin
      faults <= '0;
    end else if (cmd.commit) begin
      faults <= faults_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data.hit           <= hit;
      rsp_data.frame_index   <= idx_wide[FIDX_W-1:0];
      rsp_data.evicted_valid <= evict;
      rsp_data.evicted_page  <= evict ? ev_wide[PAGE_W-1:0] : '0;
      rsp_data.fault_count   <= faults_new;
    end
  end

  assign stat.out_free = !rsp_valid || rsp_ready;

  // a match only ever points at a frame that holds a page
  a_match_resident: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> ((match_vec & ~frame_valid) == '0))
    else $error("match on an empty frame");

  // the frame chosen for eviction holds a page
  a_evict_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && evict) |-> frame_valid[lru_idx])
    else $error("eviction of an empty frame");

  // fault count never moves backward
  a_faults_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> faults >= $past(faults))
    else $error("fault count decreased");

  // no result is overwritten while it is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !cmd.commit)
    else $error("result overwritten before it was taken");

endmodule

/* hdl/lru_page_replacement_core.sv */
// channel  dir  payload                                        handshake
// req      in   page                                           valid/ready
// rsp      out  hit, frame_index, evicted_valid, evicted_page,  valid/ready
//               fault_count
// cfg      in   frames_in_use                                  valid/ready (ready held high)
//
// each request passes a lookup step for the parallel tag compare and lru
// search, then an update step for the rank update and result write; the
// next request is taken in the cycle its predecessor commits, so requests overlap.
// reset (rst, synchronous) empties all frames, clears the fault count and
// sets frames_in_use to 16. a request stalls in the update step only while
// the result register is full and rsp is not ready.
module lru_page_replacement_core import lru_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  lru_req_if.sink   req,
  lru_rsp_if.source rsp,
  lru_cfg_if.sink   cfg
);

  lru_cmd_t  cmd;
  lru_stat_t stat;

  // configuration is always taken
  assign cfg.ready = 1'b1;

  // sequencer
  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // frame store and lookup
  lru_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_page  (req.data.page),
    .cfg_we    (cfg.valid),
    .cfg_value (cfg.data.frames_in_use),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule
